[src/wsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame header parser and payload unmasker.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 63;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrLenW = 4;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_ERROR   = 3'd6
  } wsd_phase_e;

  typedef enum logic [1:0] {
    RK_HEADER  = 2'd0,
    RK_PAYLOAD = 2'd1,
    RK_ERROR   = 2'd2
  } wsd_kind_e;

  typedef enum logic [2:0] {
    EC_NONE    = 3'd0,
    EC_RSV     = 3'd1,
    EC_OPCODE  = 3'd2,
    EC_SHORT16 = 3'd3,
    EC_TOPBIT  = 3'd4,
    EC_SHORT64 = 3'd5,
    EC_CONTROL = 3'd6
  } wsd_cause_e;

  localparam logic [6:0]   LenCode16     = 7'd126;
  localparam logic [6:0]   LenCode64     = 7'd127;
  localparam logic [15:0]  MinExt16      = 16'd126;
  localparam logic [LenW-1:0] MaxCtrlLen = LenW'(125);

  typedef struct packed {
    wsd_kind_e             kind;
    logic                  fin;
    logic [3:0]            opcode;
    logic                  masked;
    logic [LenW-1:0]       length;
    logic [KeyW-1:0]       key;
    logic [HdrLenW-1:0]    hdr_len;
    logic [ByteW-1:0]      data;
    logic                  last;
    wsd_cause_e            cause;
  } wsd_result_t;

endpackage

[src/wsd_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer input register
// Holds one incoming byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [wsd_pkg::ByteW-1:0] data_byte_i,
  input  logic                     take_i,
  output logic                     valid_o,
  output logic [wsd_pkg::ByteW-1:0] byte_o
);
  import wsd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[src/wsd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Header state machine, length and key collection, payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [wsd_pkg::ByteW-1:0] byte_i,
  output logic                      res_valid_o,
  output wsd_pkg::wsd_result_t      res_o
);
  import wsd_pkg::*;

  wsd_phase_e         phase_q, phase_d;
  logic [HdrLenW-1:0] cnt_q, cnt_d;
  logic [1:0]         kidx_q, kidx_d;
  logic               mask_q, mask_d;
  wsd_cause_e         cause_q, cause_d;
  logic [ByteW-1:0]   first_q, first_d;
  logic [63:0]        acc_q, acc_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [LenW-1:0]    rem_q, rem_d;

  always_comb begin
    logic               do_len;
    logic               do_fin;
    logic               err;
    wsd_cause_e         err_c;
    logic [LenW-1:0]    len_v;
    logic [63:0]        acc_sh;
    logic [15:0]        acc16;
    logic [3:0]         opc;
    logic [ByteW-1:0]   kb;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    kidx_d  = kidx_q;
    mask_d  = mask_q;
    cause_d = cause_q;
    first_d = first_q;
    acc_d   = acc_q;
    key_d   = key_q;
    rem_d   = rem_q;
    do_len  = 1'b0;
    do_fin  = 1'b0;
    err     = 1'b0;
    err_c   = cause_q;
    len_v   = acc_q[LenW-1:0];
    acc_sh  = {acc_q[55:0], byte_i};
    acc16   = {acc_q[7:0], byte_i};
    opc     = first_q[3:0];
    kb      = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PH_FIRST: begin
        first_d = byte_i;
        cnt_d   = HdrLenW'(1);
        acc_d   = '0;
        key_d   = '0;
        mask_d  = 1'b0;
        phase_d = PH_SECOND;
      end
      PH_SECOND: begin
        cnt_d = HdrLenW'(2);
        if (first_q[6:4] != 3'd0) begin
          err   = 1'b1;
          err_c = EC_RSV;
        end else if (opc inside {[4'h3:4'h7], [4'hB:4'hF]}) begin
          err   = 1'b1;
          err_c = EC_OPCODE;
        end else begin
          mask_d = byte_i[7];
          acc_d  = '0;
          if (byte_i[6:0] == LenCode16) begin
            phase_d = PH_EXT16;
          end else if (byte_i[6:0] == LenCode64) begin
            phase_d = PH_EXT64;
          end else begin
            acc_d  = {57'd0, byte_i[6:0]};
            len_v  = {56'd0, byte_i[6:0]};
            do_len = 1'b1;
          end
        end
      end
      PH_EXT16: begin
        acc_d = {48'd0, acc16};
        cnt_d = cnt_q + HdrLenW'(1);
        if (cnt_q == HdrLenW'(3)) begin
          if (acc16 < MinExt16) begin
            err   = 1'b1;
            err_c = EC_SHORT16;
          end else begin
            len_v  = {47'd0, acc16};
            do_len = 1'b1;
          end
        end
      end
      PH_EXT64: begin
        acc_d = acc_sh;
        cnt_d = cnt_q + HdrLenW'(1);
        if (cnt_q == HdrLenW'(9)) begin
          if (acc_sh[63]) begin
            err   = 1'b1;
            err_c = EC_TOPBIT;
          end else if (acc_sh[62:16] == 47'd0) begin
            err   = 1'b1;
            err_c = EC_SHORT64;
          end else begin
            len_v  = acc_sh[LenW-1:0];
            do_len = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_d  = {key_q[23:0], byte_i};
        cnt_d  = cnt_q + HdrLenW'(1);
        kidx_d = kidx_q + 2'd1;
        if (kidx_q == 2'd3) begin
          do_fin = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        case (kidx_q)
          2'd0:    kb = key_q[31:24];
          2'd1:    kb = key_q[23:16];
          2'd2:    kb = key_q[15:8];
          default: kb = key_q[7:0];
        endcase
        kidx_d      = kidx_q + 2'd1;
        res_valid_o = 1'b1;
        res_o.kind  = RK_PAYLOAD;
        res_o.data  = byte_i ^ kb;
        if (rem_q != '0) begin
          rem_d = rem_q - LenW'(1);
        end
        if (rem_q <= LenW'(1)) begin
          res_o.last = 1'b1;
          phase_d    = PH_FIRST;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (do_len) begin
      if (mask_d) begin
        phase_d = PH_KEY;
        kidx_d  = 2'd0;
        key_d   = '0;
      end else begin
        do_fin = 1'b1;
      end
    end

    if (do_fin) begin
      if (opc[3] && (!first_q[7] || len_v > MaxCtrlLen)) begin
        err   = 1'b1;
        err_c = EC_CONTROL;
      end else begin
        res_valid_o   = 1'b1;
        res_o.kind    = RK_HEADER;
        res_o.fin     = first_q[7];
        res_o.opcode  = opc;
        res_o.masked  = mask_d;
        res_o.length  = len_v;
        res_o.key     = mask_d ? key_d : '0;
        res_o.hdr_len = cnt_d;
        res_o.last    = (len_v == '0);
        kidx_d        = 2'd0;
        rem_d         = len_v;
        phase_d       = (len_v == '0) ? PH_FIRST : PH_PAYLOAD;
      end
    end

    if (err) begin
      phase_d     = PH_ERROR;
      cause_d     = err_c;
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.kind  = RK_ERROR;
      res_o.cause = err_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      cnt_q   <= '0;
      kidx_q  <= '0;
      mask_q  <= 1'b0;
      cause_q <= EC_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      kidx_q  <= kidx_d;
      mask_q  <= mask_d;
      cause_q <= cause_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      first_q <= first_d;
      acc_q   <= acc_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
    end
  end

endmodule

[src/wsd_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  wsd_pkg::wsd_result_t res_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wsd_pkg::wsd_result_t res_o
);
  import wsd_pkg::*;

  logic        valid_q, valid_d;
  wsd_result_t res_q;

  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[src/websocket_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a byte stream and unmasks the payload bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Beat contents
//  in      | input     | in_valid_i/in_ready_o  | data_byte_i
//  out     | output    | out_valid_o/out_ready_i| result_kind_o and frame fields
//
// One byte per cycle is sustained while the output is not stalled; each byte
// passes the input register and its result the result register.
// Header bytes that complete nothing give no result beat.
// Reset returns the parser to the first header byte and clears the error.
// A stalled output holds its beat while the input register keeps one byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wsd_pkg::ByteW-1:0]    data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   result_kind_o,
  output logic                         frame_fin_o,
  output logic [3:0]                   frame_opcode_o,
  output logic                         frame_masked_o,
  output logic [wsd_pkg::LenW-1:0]     payload_length_o,
  output logic [wsd_pkg::KeyW-1:0]     mask_key_o,
  output logic [wsd_pkg::HdrLenW-1:0]  header_length_o,
  output logic [wsd_pkg::ByteW-1:0]    payload_byte_o,
  output logic                         last_of_payload_o,
  output logic [2:0]                   error_cause_o
);
  import wsd_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_q;
  logic             space;
  logic             step;
  logic             res_valid;
  wsd_result_t      res;
  wsd_result_t      res_q;

  assign step = byte_valid && space;

  wsd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .take_i      (step),
    .valid_o     (byte_valid),
    .byte_o      (byte_q)
  );

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign result_kind_o     = res_q.kind;
  assign frame_fin_o       = res_q.fin;
  assign frame_opcode_o    = res_q.opcode;
  assign frame_masked_o    = res_q.masked;
  assign payload_length_o  = res_q.length;
  assign mask_key_o        = res_q.key;
  assign header_length_o   = res_q.hdr_len;
  assign payload_byte_o    = res_q.data;
  assign last_of_payload_o = res_q.last;
  assign error_cause_o     = res_q.cause;

endmodule

[src/wsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Checks input and result beats on the top-level ports over time.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [wsd_pkg::ByteW-1:0]    data_byte_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   result_kind_o,
  input logic                         frame_fin_o,
  input logic [3:0]                   frame_opcode_o,
  input logic                         frame_masked_o,
  input logic [wsd_pkg::LenW-1:0]     payload_length_o,
  input logic [wsd_pkg::KeyW-1:0]     mask_key_o,
  input logic [wsd_pkg::HdrLenW-1:0]  header_length_o,
  input logic [wsd_pkg::ByteW-1:0]    payload_byte_o,
  input logic                         last_of_payload_o,
  input logic [2:0]                   error_cause_o
);
  import wsd_pkg::*;

  logic hdr_beat;
  logic pay_beat;
  logic err_beat;

  assign hdr_beat = out_valid_o && (result_kind_o == RK_HEADER);
  assign pay_beat = out_valid_o && (result_kind_o == RK_PAYLOAD);
  assign err_beat = out_valid_o && (result_kind_o == RK_ERROR);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(data_byte_i))
    else $error("Input beat changed while stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(payload_byte_o))
    else $error("Result beat changed while stalled.");

  a_hdr_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_beat |-> (last_of_payload_o == (payload_length_o == '0))
      && (frame_masked_o || mask_key_o == '0)
      && (header_length_o >= HdrLenW'(2)) && (header_length_o <= HdrLenW'(14)))
    else $error("Header beat fields are inconsistent.");

  a_pay_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_beat |-> payload_length_o == '0 && mask_key_o == '0 && frame_fin_o == 1'b0
      && frame_opcode_o == 4'd0 && error_cause_o == EC_NONE)
    else $error("Payload beat carries header or error fields.");

  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_beat |-> error_cause_o != EC_NONE && payload_byte_o == '0
      && last_of_payload_o == 1'b0)
    else $error("Error beat without a cause.");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

[verif/websocket_frame_deframer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer checker
// Watches the byte and result channels of the deframer. For every accepted
// byte it runs its own header parser and unmasker, queues any result beat that
// byte should cause, and compares every accepted result beat with the oldest
// queued one. It reports the failure count and the number of beats still owed.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [wsd_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [1:0]                   result_kind_i,
  input  logic                         frame_fin_i,
  input  logic [3:0]                   frame_opcode_i,
  input  logic                         frame_masked_i,
  input  logic [wsd_pkg::LenW-1:0]     payload_length_i,
  input  logic [wsd_pkg::KeyW-1:0]     mask_key_i,
  input  logic [wsd_pkg::HdrLenW-1:0]  header_length_i,
  input  logic [wsd_pkg::ByteW-1:0]    payload_byte_i,
  input  logic                         last_of_payload_i,
  input  logic [2:0]                   error_cause_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o
);
  import wsd_pkg::*;

  localparam logic [3:0]  OpRsvDataLo = 4'h3;
  localparam logic [3:0]  OpRsvDataHi = 4'h7;
  localparam logic [3:0]  OpRsvCtrlLo = 4'hB;
  localparam int unsigned FinBit      = 7;
  localparam int unsigned CtrlBit     = 3;
  localparam logic [3:0]  Ext16Bytes  = 4'd4;
  localparam logic [3:0]  Ext64Bytes  = 4'd10;
  localparam logic [63:0] Max16       = 64'hFFFF;
  localparam int unsigned ReportMax   = 10;

  wsd_phase_e       stage;
  logic [3:0]       hdr_count;
  logic [7:0]       byte0;
  logic [63:0]      len_acc;
  logic [KeyW-1:0]  key_reg;
  logic [LenW-1:0]  remaining;
  logic [1:0]       key_idx;
  logic             err_hit;
  logic             masked_f;
  wsd_cause_e       err_cause;
  wsd_result_t      expected_beats[$];
  int unsigned      fail_count = 0;

  function automatic logic latch_error(input wsd_cause_e cause, output wsd_result_t r);
    err_hit   = 1'b1;
    err_cause = cause;
    stage     = PH_ERROR;
    r         = '0;
    r.kind    = RK_ERROR;
    r.cause   = cause;
    return 1'b1;
  endfunction

  function automatic logic close_header(output wsd_result_t r);
    logic [LenW-1:0] len;
    len = len_acc[LenW-1:0];
    if (byte0[CtrlBit] && (!byte0[FinBit] || len > MaxCtrlLen)) begin
      return latch_error(EC_CONTROL, r);
    end
    r         = '0;
    r.kind    = RK_HEADER;
    r.fin     = byte0[FinBit];
    r.opcode  = byte0[3:0];
    r.masked  = masked_f;
    r.length  = len;
    r.key     = masked_f ? key_reg : '0;
    r.hdr_len = hdr_count;
    r.last    = (len == '0);
    if (!masked_f) key_reg = '0;
    key_idx   = '0;
    remaining = len;
    stage     = (len == '0) ? PH_FIRST : PH_PAYLOAD;
    return 1'b1;
  endfunction

  function automatic logic length_known(output wsd_result_t r);
    r = '0;
    if (masked_f) begin
      stage   = PH_KEY;
      key_idx = '0;
      key_reg = '0;
      return 1'b0;
    end
    return close_header(r);
  endfunction

  function automatic logic deframe_byte(input logic [7:0] b, output wsd_result_t r);
    logic [3:0] opc;
    r = '0;
    if (err_hit) return latch_error(err_cause, r);
    case (stage)
      PH_FIRST: begin
        byte0     = b;
        hdr_count = 4'd1;
        len_acc   = '0;
        key_reg   = '0;
        masked_f  = 1'b0;
        stage     = PH_SECOND;
        return 1'b0;
      end
      PH_SECOND: begin
        opc       = byte0[3:0];
        hdr_count = 4'd2;
        if (byte0[6:4] != 3'd0) return latch_error(EC_RSV, r);
        if ((opc >= OpRsvDataLo && opc <= OpRsvDataHi) || opc >= OpRsvCtrlLo) begin
          return latch_error(EC_OPCODE, r);
        end
        masked_f = b[7];
        len_acc  = '0;
        if (b[6:0] == LenCode16) begin
          stage = PH_EXT16;
          return 1'b0;
        end
        if (b[6:0] == LenCode64) begin
          stage = PH_EXT64;
          return 1'b0;
        end
        len_acc = {57'd0, b[6:0]};
        return length_known(r);
      end
      PH_EXT16: begin
        len_acc   = {48'd0, len_acc[7:0], b};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count < Ext16Bytes) return 1'b0;
        if (len_acc[15:0] < MinExt16) return latch_error(EC_SHORT16, r);
        return length_known(r);
      end
      PH_EXT64: begin
        len_acc   = {len_acc[55:0], b};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count < Ext64Bytes) return 1'b0;
        if (len_acc[63]) return latch_error(EC_TOPBIT, r);
        if (len_acc <= Max16) return latch_error(EC_SHORT64, r);
        return length_known(r);
      end
      PH_KEY: begin
        key_reg   = {key_reg[23:0], b};
        hdr_count = hdr_count + 4'd1;
        key_idx   = key_idx + 2'd1;
        if (key_idx != 2'd0) return 1'b0;
        return close_header(r);
      end
      PH_PAYLOAD: begin
        r.kind  = RK_PAYLOAD;
        r.data  = b ^ key_reg[31 - 8 * key_idx -: 8];
        key_idx = key_idx + 2'd1;
        if (remaining != '0) remaining = remaining - 1'b1;
        if (remaining == '0) begin
          r.last = 1'b1;
          stage  = PH_FIRST;
        end
        return 1'b1;
      end
      default: return latch_error(err_cause, r);
    endcase
  endfunction

  function automatic bit same_beat(input wsd_result_t a, input wsd_result_t b);
    return a.kind === b.kind && a.fin === b.fin && a.opcode === b.opcode &&
           a.masked === b.masked && a.length === b.length && a.key === b.key &&
           a.hdr_len === b.hdr_len && a.data === b.data && a.last === b.last &&
           a.cause === b.cause;
  endfunction

  function automatic string beat_text(input wsd_result_t r);
    return $sformatf({"kind=%0d fin=%0d op=%h mask=%0d len=%h key=%h",
                      " hlen=%0d data=%h last=%0d cause=%0d"},
                     r.kind, r.fin, r.opcode, r.masked, r.length, r.key, r.hdr_len,
                     r.data, r.last, r.cause);
  endfunction

  always @(posedge clk_i) begin
    wsd_result_t want;
    wsd_result_t got;
    if (!rst_ni) begin
      stage     = PH_FIRST;
      hdr_count = '0;
      byte0     = '0;
      len_acc   = '0;
      key_reg   = '0;
      remaining = '0;
      key_idx   = '0;
      err_hit   = 1'b0;
      masked_f  = 1'b0;
      err_cause = EC_NONE;
      expected_beats.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(data_byte_i, want)) expected_beats.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got.kind    = wsd_kind_e'(result_kind_i);
        got.fin     = frame_fin_i;
        got.opcode  = frame_opcode_i;
        got.masked  = frame_masked_i;
        got.length  = payload_length_i;
        got.key     = mask_key_i;
        got.hdr_len = header_length_i;
        got.data    = payload_byte_i;
        got.last    = last_of_payload_i;
        got.cause   = wsd_cause_e'(error_cause_i);
        if (expected_beats.size() == 0) begin
          if (fail_count < ReportMax) begin
            $display("%0t: result beat with nothing expected: %s", $time, beat_text(got));
          end
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (!same_beat(want, got)) begin
            if (fail_count < ReportMax) begin
              $display("%0t: result beat mismatch", $time);
              $display("  expected %s", beat_text(want));
              $display("  actual   %s", beat_text(got));
            end
            fail_count++;
          end
        end
      end
    end
    mismatches_o <= fail_count;
    pending_o    <= expected_beats.size();
  end

endmodule

[verif/tb_websocket_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds a byte stream of well-formed frames of every opcode, masked and
// unmasked, with 7-bit and 16-bit lengths, under random idling on both sides
// and one long output stall. The stream ends with either one protocol error
// and trailing bytes, or an unfinished frame with a 64-bit length. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int unsigned IdlePct    = 9;
  localparam int unsigned ByteTarget = 1550;
  localparam int unsigned HoldAt     = 200;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CalmFrom   = 500;
  localparam int unsigned CalmTo     = 900;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned NoiseBytes = 6;
  localparam int unsigned OpenBody   = 40;

  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;

  typedef enum int unsigned {
    ENC_7,
    ENC_16,
    ENC_64
  } len_enc_e;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          result_kind_o;
  logic                frame_fin_o;
  logic [3:0]          frame_opcode_o;
  logic                frame_masked_o;
  logic [LenW-1:0]     payload_length_o;
  logic [KeyW-1:0]     mask_key_o;
  logic [HdrLenW-1:0]  header_length_o;
  logic [ByteW-1:0]    payload_byte_o;
  logic                last_of_payload_o;
  logic [2:0]          error_cause_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent_bytes = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;

  websocket_frame_deframer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .frame_fin_o       (frame_fin_o),
    .frame_opcode_o    (frame_opcode_o),
    .frame_masked_o    (frame_masked_o),
    .payload_length_o  (payload_length_o),
    .mask_key_o        (mask_key_o),
    .header_length_o   (header_length_o),
    .payload_byte_o    (payload_byte_o),
    .last_of_payload_o (last_of_payload_o),
    .error_cause_o     (error_cause_o)
  );

  websocket_frame_deframer_checker deframe_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_i     (result_kind_o),
    .frame_fin_i       (frame_fin_o),
    .frame_opcode_i    (frame_opcode_o),
    .frame_masked_i    (frame_masked_o),
    .payload_length_i  (payload_length_o),
    .mask_key_i        (mask_key_o),
    .header_length_i   (header_length_o),
    .payload_byte_i    (payload_byte_o),
    .last_of_payload_i (last_of_payload_o),
    .error_cause_i     (error_cause_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] any_data_op();
    case ($urandom_range(2))
      0: return OpCont;
      1: return OpText;
      default: return OpBin;
    endcase
  endfunction

  function automatic logic [3:0] any_ctrl_op();
    case ($urandom_range(2))
      0: return OpClose;
      1: return OpPing;
      default: return OpPong;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_bytes++;
    if (sent_bytes == HoldAt) hold_req = 1'b1;
    calm = (sent_bytes >= CalmFrom && sent_bytes < CalmTo);
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                            input logic masked, input logic [63:0] len, input len_enc_e enc,
                            input int unsigned body, input int fill);
    logic [31:0] key;
    key = (fill < 0) ? $urandom : {4{fill[7:0]}};
    send_byte({fin, rsv, opc});
    case (enc)
      ENC_7: send_byte({masked, len[6:0]});
      ENC_16: begin
        send_byte({masked, LenCode16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LenCode64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    for (int unsigned n = 0; n < body; n++) begin
      send_byte((fill < 0) ? 8'($urandom) : fill[7:0]);
    end
  endtask

  task automatic send_random_frame();
    logic [63:0]  len;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      len = 64'($urandom_range((pick < 3) ? 125 : 12));
      send_frame(1'b1, 3'd0, any_ctrl_op(), 1'($urandom), len, ENC_7, 32'(len), -1);
    end else if (pick < 85) begin
      len = 64'($urandom_range((pick < 55) ? 8 : 125));
      send_frame(1'($urandom), 3'd0, any_data_op(), 1'($urandom), len, ENC_7, 32'(len), -1);
    end else begin
      len = 64'($urandom_range(320, MinExt16));
      send_frame(1'($urandom), 3'd0, any_data_op(), 1'($urandom), len, ENC_16, 32'(len),
                 -1);
    end
  endtask

  task automatic finish_stream();
    wsd_cause_e   tail;
    logic [63:0]  len;
    logic [3:0]   opc;
    tail = wsd_cause_e'($urandom_range(EC_CONTROL, EC_NONE));
    case (tail)
      EC_RSV: begin
        send_frame(1'($urandom), 3'($urandom_range(7, 1)), any_data_op(), 1'($urandom),
                   64'd4, ENC_7, 0, -1);
      end
      EC_OPCODE: begin
        opc = $urandom_range(1) ? OpBin + 4'($urandom_range(5, 1))
                                : OpPong + 4'($urandom_range(5, 1));
        send_frame(1'b1, 3'd0, opc, 1'($urandom), 64'd0, ENC_7, 0, -1);
      end
      EC_SHORT16: begin
        len = 64'($urandom_range(MinExt16 - 1));
        send_frame(1'b1, 3'd0, any_data_op(), 1'($urandom), len, ENC_16, 0, -1);
      end
      EC_TOPBIT: begin
        len = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(1'b1, 3'd0, any_data_op(), 1'($urandom), len, ENC_64, 0, -1);
      end
      EC_SHORT64: begin
        len = 64'($urandom_range(16'hFFFF));
        send_frame(1'b1, 3'd0, any_data_op(), 1'($urandom), len, ENC_64, 0, -1);
      end
      EC_CONTROL: begin
        if ($urandom_range(1)) begin
          len = 64'($urandom_range(10));
          send_frame(1'b0, 3'd0, any_ctrl_op(), 1'($urandom), len, ENC_7, 0, -1);
        end else begin
          len = 64'($urandom_range(200, MinExt16));
          send_frame(1'b1, 3'd0, any_ctrl_op(), 1'($urandom), len, ENC_16, 0, -1);
        end
      end
      default: begin
        len = {1'b0, 31'($urandom), 32'($urandom)};
        if (len <= 64'hFFFF) len = len + 64'h10000;
        send_frame(1'($urandom), 3'd0, any_data_op(), 1'($urandom), len, ENC_64,
                   OpenBody, -1);
      end
    endcase
    if (tail != EC_NONE) begin
      repeat (NoiseBytes) send_byte(8'($urandom));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("** websocket_frame_deframer: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_frame(1'b1, 3'd0, OpText, 1'b0, 64'd0, ENC_7, 0, -1);
    send_frame(1'b0, 3'd0, OpBin, 1'b1, 64'd5, ENC_7, 5, -1);
    send_frame(1'b1, 3'd0, OpCont, 1'b0, 64'd1, ENC_7, 1, 8'h00);
    send_frame(1'b1, 3'd0, OpPing, 1'b1, 64'd1, ENC_7, 1, 8'hFF);
    send_frame(1'b1, 3'd0, OpPong, 1'b0, 64'd2, ENC_7, 2, -1);
    send_frame(1'b1, 3'd0, OpClose, 1'b1, 64'd0, ENC_7, 0, 8'h00);
    while (sent_bytes < ByteTarget) send_random_frame();
    finish_stream();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("** websocket_frame_deframer: PASSED **");
    end else begin
      $display("** websocket_frame_deframer: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wsd_pkg.sv
src/wsd_in_stage.sv
src/wsd_parser.sv
src/wsd_out_stage.sv
src/websocket_frame_deframer.sv
src/wsd_checker.sv
verif/websocket_frame_deframer_checker.sv
verif/tb_websocket_frame_deframer.sv
